@@ hw/rtl/jbig2_smf_pkg.sv @@
// types and constants shared by the segment metadata filter modules
package jbig2_smf_pkg;

  typedef enum logic [3:0] {
    PH_SEG,
    PH_FLAGS,
    PH_REF0,
    PH_REFL,
    PH_RET,
    PH_REFS,
    PH_PAGE,
    PH_LEN,
    PH_PAY,
    PH_EXT,
    PH_DROP
  } phase_t;

  typedef enum logic [1:0] {
    K_NONE,
    K_BYTE,
    K_LEN,
    K_EXT
  } kind_t;

  localparam logic [2:0] ST_BYTE      = 3'd0;
  localparam logic [2:0] ST_CLEAN     = 3'd1;
  localparam logic [2:0] ST_TRUNC     = 3'd2;
  localparam logic [2:0] ST_BAD_REF   = 3'd3;
  localparam logic [2:0] ST_INDEF_LEN = 3'd4;
  localparam logic [2:0] ST_BAD_EXT   = 3'd5;
  localparam logic [2:0] ST_PAGE_SIZE = 3'd6;
  localparam logic [2:0] ST_EOF_LEN   = 3'd7;

  localparam logic [5:0]  TYPE_PAGE_INFO = 6'd48;
  localparam logic [5:0]  TYPE_EOF       = 6'd51;
  localparam logic [5:0]  TYPE_COMMENT   = 6'd62;
  localparam logic [31:0] PAGE_INFO_LEN  = 32'd19;
  localparam logic [31:0] LEN_INDEF      = 32'hffff_ffff;
  localparam logic [31:0] EXT_WORD_ONE   = 32'h2000_0000;
  localparam logic [31:0] EXT_WORD_TWO   = 32'h2000_0002;
  localparam logic [31:0] SEG_NUM_WIDE4  = 32'd65536;
  localparam logic [31:0] SEG_NUM_WIDE2  = 32'd256;
  localparam logic [2:0]  REF_TOP_LONG   = 3'd7;
  localparam logic [2:0]  REF_TOP_MAX    = 3'd4;
  localparam int          RC_W           = 29;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  b;
    logic [31:0] word;
    logic        six;
    logic        sts_en;
    logic [2:0]  sts;
  } cmd_t;

endpackage

@@ hw/rtl/jbig2_smf_front.sv @@
// header parser: one byte per accepted cycle; a byte may push a command
module jbig2_smf_front #(
  parameter int REF_LIMIT = 1000000
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [7:0]           data_byte,
  input  logic                 stream_last,
  output logic                 push,
  output jbig2_smf_pkg::cmd_t  cmd
);

  jbig2_smf_pkg::phase_t phase, phase_next;
  logic [31:0] field_count, field_count_next;
  logic [31:0] segment_number, segment_number_next;
  logic [7:0]  segment_flags, segment_flags_next;
  logic [jbig2_smf_pkg::RC_W-1:0] reference_count, reference_count_next;
  logic [31:0] payload_length, payload_length_next;
  logic [31:0] payload_index, payload_index_next;
  logic [31:0] ext_word, ext_word_next;
  logic        finished, finished_next;
  logic        failed, failed_next;

  logic [31:0] fc_inc, pi_inc, len_new, refs_len_val;
  logic [jbig2_smf_pkg::RC_W-1:0] rc_new, rc_refs;
  logic [29:0] rc_sum;
  logic [5:0]  seg_type;
  logic        do_refs;

  function automatic logic [31:0] refs_len(input logic [jbig2_smf_pkg::RC_W-1:0] rc,
                                           input logic [31:0] sn);
    logic [31:0] r;
    begin
      r = {{(32 - jbig2_smf_pkg::RC_W){1'b0}}, rc};
      if (sn > jbig2_smf_pkg::SEG_NUM_WIDE4) return r << 2;
      else if (sn > jbig2_smf_pkg::SEG_NUM_WIDE2) return r << 1;
      else return r;
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= jbig2_smf_pkg::PH_SEG;
    end else if (accept) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_count     <= '0;
      segment_number  <= '0;
      segment_flags   <= '0;
      reference_count <= '0;
      payload_length  <= '0;
      payload_index   <= '0;
      ext_word        <= '0;
      finished        <= 1'b0;
      failed          <= 1'b0;
    end else if (accept) begin
      field_count     <= field_count_next;
      segment_number  <= segment_number_next;
      segment_flags   <= segment_flags_next;
      reference_count <= reference_count_next;
      payload_length  <= payload_length_next;
      payload_index   <= payload_index_next;
      ext_word        <= ext_word_next;
      finished        <= finished_next;
      failed          <= failed_next;
    end
  end

  always_comb begin
    phase_next           = phase;
    field_count_next     = field_count;
    segment_number_next  = segment_number;
    segment_flags_next   = segment_flags;
    reference_count_next = reference_count;
    payload_length_next  = payload_length;
    payload_index_next   = payload_index;
    ext_word_next        = ext_word;
    finished_next        = finished;
    failed_next          = failed;

    cmd.kind   = jbig2_smf_pkg::K_NONE;
    cmd.b      = data_byte;
    cmd.word   = '0;
    cmd.six    = 1'b0;
    cmd.sts_en = 1'b0;
    cmd.sts    = jbig2_smf_pkg::ST_BYTE;

    fc_inc   = field_count + 32'd1;
    pi_inc   = payload_index + 32'd1;
    len_new  = {payload_length[23:0], data_byte};
    rc_new   = {reference_count[jbig2_smf_pkg::RC_W-9:0], data_byte};
    rc_sum   = {1'b0, rc_new} + 30'd8;
    seg_type = segment_flags[5:0];
    rc_refs  = reference_count;
    do_refs  = 1'b0;
    refs_len_val = '0;

    if (!finished && !failed) begin
      case (phase)
        jbig2_smf_pkg::PH_SEG: begin
          cmd.kind = jbig2_smf_pkg::K_BYTE;
          segment_number_next = (field_count == 32'd0) ? {24'd0, data_byte}
                                                        : {segment_number[23:0], data_byte};
          field_count_next = fc_inc;
          if (fc_inc == 32'd4) begin
            phase_next = jbig2_smf_pkg::PH_FLAGS;
            field_count_next = '0;
          end
        end
        jbig2_smf_pkg::PH_FLAGS: begin
          cmd.kind = jbig2_smf_pkg::K_BYTE;
          segment_flags_next = data_byte;
          phase_next = jbig2_smf_pkg::PH_REF0;
        end
        jbig2_smf_pkg::PH_REF0: begin
          cmd.kind = jbig2_smf_pkg::K_BYTE;
          if (data_byte[7:5] == jbig2_smf_pkg::REF_TOP_LONG) begin
            reference_count_next = {{(jbig2_smf_pkg::RC_W - 5){1'b0}}, data_byte[4:0]};
            phase_next = jbig2_smf_pkg::PH_REFL;
            field_count_next = '0;
          end else if (data_byte[7:5] > jbig2_smf_pkg::REF_TOP_MAX) begin
            cmd.sts_en = 1'b1;
            cmd.sts = jbig2_smf_pkg::ST_BAD_REF;
            failed_next = 1'b1;
          end else begin
            reference_count_next = {{(jbig2_smf_pkg::RC_W - 3){1'b0}}, data_byte[7:5]};
            rc_refs = {{(jbig2_smf_pkg::RC_W - 3){1'b0}}, data_byte[7:5]};
            do_refs = 1'b1;
          end
        end
        jbig2_smf_pkg::PH_REFL: begin
          cmd.kind = jbig2_smf_pkg::K_BYTE;
          reference_count_next = rc_new;
          field_count_next = fc_inc;
          if (fc_inc == 32'd3) begin
            if (rc_new > jbig2_smf_pkg::RC_W'(REF_LIMIT)) begin
              cmd.sts_en = 1'b1;
              cmd.sts = jbig2_smf_pkg::ST_BAD_REF;
              failed_next = 1'b1;
            end else begin
              payload_length_next = {5'd0, rc_sum[29:3]};
              phase_next = jbig2_smf_pkg::PH_RET;
              field_count_next = '0;
            end
          end
        end
        jbig2_smf_pkg::PH_RET: begin
          cmd.kind = jbig2_smf_pkg::K_BYTE;
          field_count_next = fc_inc;
          if (fc_inc >= payload_length) do_refs = 1'b1;
        end
        jbig2_smf_pkg::PH_REFS: begin
          cmd.kind = jbig2_smf_pkg::K_BYTE;
          field_count_next = fc_inc;
          if (fc_inc >= payload_length) begin
            payload_length_next = segment_flags[6] ? 32'd4 : 32'd1;
            phase_next = jbig2_smf_pkg::PH_PAGE;
            field_count_next = '0;
          end
        end
        jbig2_smf_pkg::PH_PAGE: begin
          cmd.kind = jbig2_smf_pkg::K_BYTE;
          field_count_next = fc_inc;
          if (fc_inc >= payload_length) begin
            phase_next = jbig2_smf_pkg::PH_LEN;
            field_count_next = '0;
            payload_length_next = '0;
          end
        end
        jbig2_smf_pkg::PH_LEN: begin
          payload_length_next = len_new;
          field_count_next = fc_inc;
          if (fc_inc == 32'd4) begin
            if (len_new == jbig2_smf_pkg::LEN_INDEF) begin
              cmd.sts_en = 1'b1;
              cmd.sts = jbig2_smf_pkg::ST_INDEF_LEN;
              failed_next = 1'b1;
            end else if (seg_type == jbig2_smf_pkg::TYPE_COMMENT) begin
              if (len_new < 32'd4) begin
                cmd.sts_en = 1'b1;
                cmd.sts = jbig2_smf_pkg::ST_BAD_EXT;
                failed_next = 1'b1;
              end else begin
                phase_next = jbig2_smf_pkg::PH_EXT;
                payload_index_next = '0;
              end
            end else if (seg_type == jbig2_smf_pkg::TYPE_PAGE_INFO &&
                         len_new != jbig2_smf_pkg::PAGE_INFO_LEN) begin
              cmd.sts_en = 1'b1;
              cmd.sts = jbig2_smf_pkg::ST_PAGE_SIZE;
              failed_next = 1'b1;
            end else if (seg_type == jbig2_smf_pkg::TYPE_EOF && len_new != 32'd0) begin
              cmd.sts_en = 1'b1;
              cmd.sts = jbig2_smf_pkg::ST_EOF_LEN;
              failed_next = 1'b1;
            end else begin
              cmd.kind = jbig2_smf_pkg::K_LEN;
              cmd.word = len_new;
              if (seg_type == jbig2_smf_pkg::TYPE_EOF) begin
                cmd.sts_en = 1'b1;
                cmd.sts = jbig2_smf_pkg::ST_CLEAN;
                finished_next = 1'b1;
              end else if (len_new == 32'd0) begin
                phase_next = jbig2_smf_pkg::PH_SEG;
                field_count_next = '0;
              end else begin
                phase_next = jbig2_smf_pkg::PH_PAY;
                payload_index_next = '0;
              end
            end
          end
        end
        jbig2_smf_pkg::PH_PAY: begin
          cmd.kind = jbig2_smf_pkg::K_BYTE;
          if (seg_type == jbig2_smf_pkg::TYPE_PAGE_INFO &&
              payload_index >= 32'd8 && payload_index < 32'd16) begin
            cmd.b = 8'd0;
          end
          payload_index_next = pi_inc;
          if (pi_inc >= payload_length) begin
            phase_next = jbig2_smf_pkg::PH_SEG;
            field_count_next = '0;
          end
        end
        jbig2_smf_pkg::PH_EXT: begin
          ext_word_next = {ext_word[23:0], data_byte};
          payload_index_next = pi_inc;
          if (pi_inc == 32'd4) begin
            if (ext_word_next == jbig2_smf_pkg::EXT_WORD_ONE ||
                ext_word_next == jbig2_smf_pkg::EXT_WORD_TWO) begin
              cmd.kind = jbig2_smf_pkg::K_EXT;
              cmd.word = ext_word_next;
              cmd.six = (ext_word_next == jbig2_smf_pkg::EXT_WORD_TWO);
              if (payload_length == 32'd4) begin
                phase_next = jbig2_smf_pkg::PH_SEG;
                field_count_next = '0;
              end else begin
                phase_next = jbig2_smf_pkg::PH_DROP;
              end
            end else begin
              cmd.sts_en = 1'b1;
              cmd.sts = jbig2_smf_pkg::ST_BAD_EXT;
              failed_next = 1'b1;
            end
          end
        end
        jbig2_smf_pkg::PH_DROP: begin
          payload_index_next = pi_inc;
          if (pi_inc >= payload_length) begin
            phase_next = jbig2_smf_pkg::PH_SEG;
            field_count_next = '0;
          end
        end
        default: begin
          phase_next = jbig2_smf_pkg::PH_SEG;
          field_count_next = '0;
        end
      endcase

      // referred-to list length, then page association if the list is empty
      if (do_refs) begin
        refs_len_val = refs_len(rc_refs, segment_number);
        if (refs_len_val == 32'd0) begin
          payload_length_next = segment_flags[6] ? 32'd4 : 32'd1;
          phase_next = jbig2_smf_pkg::PH_PAGE;
        end else begin
          payload_length_next = refs_len_val;
          phase_next = jbig2_smf_pkg::PH_REFS;
        end
        field_count_next = '0;
      end

      if (stream_last && !finished_next && !failed_next) begin
        cmd.sts_en = 1'b1;
        cmd.sts = (phase_next == jbig2_smf_pkg::PH_SEG && field_count_next == 32'd0)
                  ? jbig2_smf_pkg::ST_CLEAN : jbig2_smf_pkg::ST_TRUNC;
      end
    end

    // stream end returns the parser to its reset state
    if (stream_last) begin
      phase_next           = jbig2_smf_pkg::PH_SEG;
      field_count_next     = '0;
      segment_number_next  = '0;
      segment_flags_next   = '0;
      reference_count_next = '0;
      payload_length_next  = '0;
      payload_index_next   = '0;
      ext_word_next        = '0;
      finished_next        = 1'b0;
      failed_next          = 1'b0;
    end

    push = accept && (cmd.kind != jbig2_smf_pkg::K_NONE || cmd.sts_en);
  end

endmodule

@@ hw/rtl/jbig2_smf_queue.sv @@
// small command queue between the parser and the output expander
module jbig2_smf_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  jbig2_smf_pkg::cmd_t  push_cmd,
  output logic                 not_full,
  input  logic                 pop,
  output logic                 head_valid,
  output jbig2_smf_pkg::cmd_t  head
);

  jbig2_smf_pkg::cmd_t entries [jbig2_smf_pkg::QUEUE_DEPTH];
  logic [jbig2_smf_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [jbig2_smf_pkg::QPTR_W:0]   count;

  assign not_full   = (count != (jbig2_smf_pkg::QPTR_W + 1)'(jbig2_smf_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

@@ hw/rtl/jbig2_smf_back.sv @@
// output expander: turns each command into its run of result items
module jbig2_smf_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 head_valid,
  input  jbig2_smf_pkg::cmd_t  head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic [2:0]           status,
  output logic                 run_last
);

  logic [3:0] idx;
  logic [3:0] body, total;
  logic       load, last_res;
  logic [7:0] res_byte;
  logic [2:0] res_sts;

  always_comb begin
    case (head.kind)
      jbig2_smf_pkg::K_BYTE: body = 4'd1;
      jbig2_smf_pkg::K_LEN:  body = 4'd4;
      jbig2_smf_pkg::K_EXT:  body = head.six ? 4'd10 : 4'd9;
      default:               body = 4'd0;
    endcase
    total    = body + {3'd0, head.sts_en};
    last_res = (idx == total - 4'd1);
    load     = head_valid && (!out_valid || out_ready);
    pop      = load && last_res;

    res_byte = 8'd0;
    res_sts  = jbig2_smf_pkg::ST_BYTE;
    if (idx >= body) begin
      res_sts = head.sts;
    end else begin
      case (head.kind)
        jbig2_smf_pkg::K_BYTE: res_byte = head.b;
        jbig2_smf_pkg::K_LEN: begin
          case (idx[1:0])
            2'd0:    res_byte = head.word[31:24];
            2'd1:    res_byte = head.word[23:16];
            2'd2:    res_byte = head.word[15:8];
            default: res_byte = head.word[7:0];
          endcase
        end
        jbig2_smf_pkg::K_EXT: begin
          case (idx)
            4'd3:    res_byte = head.six ? 8'd6 : 8'd5;
            4'd4:    res_byte = head.word[31:24];
            4'd5:    res_byte = head.word[23:16];
            4'd6:    res_byte = head.word[15:8];
            4'd7:    res_byte = head.word[7:0];
            default: res_byte = 8'd0;
          endcase
        end
        default: res_byte = 8'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else if (load) begin
      idx       <= last_res ? 4'd0 : idx + 4'd1;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= res_byte;
      status   <= res_sts;
      run_last <= last_res;
    end
  end

endmodule

@@ hw/rtl/jbig2_segment_metadata_filter.sv @@
// top level of the segment metadata filter
//  channel | signals                                   | handshake
//  input   | data_byte[7:0], stream_last               | in_valid / in_ready
//  output  | out_byte[7:0], status[2:0], run_last      | out_valid / out_ready
// one byte is accepted per cycle while the command queue has room
// each byte gives 0 to 11 result items, one per cycle from the output register while out_ready is high
// a comment extension word gives a burst of up to 11 items, absorbed by the queue
// a byte's command passes through the queue and then the output register before its first result
// rst is synchronous and empties the queue and the output register
module jbig2_segment_metadata_filter #(
  parameter int REF_LIMIT = 1000000
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       stream_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [2:0] status,
  output logic       run_last
);

  logic                push, pop, head_valid, not_full, accept;
  jbig2_smf_pkg::cmd_t cmd, head;

  assign in_ready = not_full;
  assign accept   = in_valid && in_ready;

  jbig2_smf_front #(
    .REF_LIMIT(REF_LIMIT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (data_byte),
    .stream_last(stream_last),
    .push       (push),
    .cmd        (cmd)
  );

  jbig2_smf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (cmd),
    .not_full  (not_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head      (head)
  );

  jbig2_smf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .status    (status),
    .run_last  (run_last)
  );

endmodule

@@ hw/rtl/jbig2_smf_checker.sv @@
// port-level checks for the segment metadata filter, bound to the top level
module jbig2_smf_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic [2:0] status,
  input logic       run_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(status) &&
    $stable(run_last))
    else $error("output item changed while stalled");

  a_status_zero_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != jbig2_smf_pkg::ST_BYTE |-> out_byte == 8'd0)
    else $error("status item carries a nonzero byte");

  a_status_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != jbig2_smf_pkg::ST_BYTE |-> run_last)
    else $error("status item is not the last of its run");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("block not empty after reset");

endmodule

bind jbig2_segment_metadata_filter jbig2_smf_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_byte (out_byte),
  .status   (status),
  .run_last (run_last)
);

@@ verif/jbig2_segment_metadata_filter_test.sv @@
// self-checking testbench for the jbig2 segment metadata filter
`timescale 1ns / 1ps

module jbig2_segment_metadata_filter_test;
  import jbig2_smf_pkg::*;

  localparam int REF_MAX = 1000000;
  localparam int RAND_ITEMS = 220;
  localparam int HOLD_CYCLES = 80;
  localparam int BY_MODEL = -1;

  typedef struct packed {
    logic [7:0] b;
    logic [2:0] st;
    logic       lst;
  } res_t;

  typedef struct {
    logic [7:0] b;
    logic       l;
    int         n;
    res_t       r0;
    res_t       r1;
  } row_t;

  typedef enum int {
    SEG_PLAIN,
    SEG_PAGE,
    SEG_COMMENT,
    SEG_EOF,
    SEG_BAD_SHORT,
    SEG_BAD_LONG,
    SEG_NEAR_LIMIT,
    SEG_INDEF,
    SEG_SHORT_NOTE,
    SEG_BAD_WORD,
    SEG_PAGE_SIZE,
    SEG_EOF_LEN
  } seg_kind_t;

  localparam res_t NIL = '0;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte = 8'h00;
  logic       stream_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic [2:0] status;
  logic       run_last;

  jbig2_segment_metadata_filter #(.REF_LIMIT(REF_MAX)) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .stream_last(stream_last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte(out_byte),
    .status(status),
    .run_last(run_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // filter state mirror
  phase_t      ph;
  logic [31:0] fcnt;
  logic [31:0] seg_num;
  logic [7:0]  seg_flags;
  logic [31:0] ref_cnt;
  logic [31:0] pay_len;
  logic [31:0] pay_idx;
  logic [7:0]  held [8];
  bit          eof_seen;
  bit          stream_bad;

  res_t        step_out [$];
  res_t        filtered_q [$];
  row_t        plan [$];
  logic [7:0]  strm [$];

  int tx_pct = 0;
  int rx_pct = 0;
  int hold_ask = 0;
  int hold_done = 0;
  int hold_left = 0;
  int misses = 0;

  function automatic void filter_reset();
    ph = PH_SEG;
    fcnt = 0;
    seg_num = 0;
    seg_flags = 0;
    ref_cnt = 0;
    pay_len = 0;
    pay_idx = 0;
    foreach (held[i]) held[i] = 8'h00;
    eof_seen = 0;
    stream_bad = 0;
  endfunction

  function automatic void put(input logic [7:0] b, input logic [2:0] st);
    step_out.push_back(res_t'{b, st, 1'b0});
  endfunction

  function automatic void abort(input logic [2:0] st);
    put(8'h00, st);
    stream_bad = 1;
  endfunction

  function automatic void seg_close();
    ph = PH_SEG;
    fcnt = 0;
  endfunction

  function automatic void to_page();
    pay_len = seg_flags[6] ? 32'd4 : 32'd1;
    ph = PH_PAGE;
    fcnt = 0;
  endfunction

  function automatic void to_refs();
    logic [31:0] w;
    w = (seg_num > SEG_NUM_WIDE4) ? 32'd4 : ((seg_num > SEG_NUM_WIDE2) ? 32'd2 : 32'd1);
    pay_len = ref_cnt * w;
    if (pay_len == 0) begin
      to_page();
    end else begin
      ph = PH_REFS;
      fcnt = 0;
    end
  endfunction

  // works out the results that one accepted byte causes
  task automatic filter_byte(input logic [7:0] b, input logic l, output bit act);
    logic [2:0]  top;
    logic [5:0]  ty;
    logic [31:0] word;
    bit          six;
    step_out.delete();
    act = !eof_seen && !stream_bad;
    ty = seg_flags[5:0];
    if (act) begin
      case (ph)
        PH_SEG: begin
          put(b, ST_BYTE);
          seg_num = (fcnt == 0) ? {24'd0, b} : {seg_num[23:0], b};
          fcnt++;
          if (fcnt == 4) begin
            ph = PH_FLAGS;
            fcnt = 0;
          end
        end
        PH_FLAGS: begin
          put(b, ST_BYTE);
          seg_flags = b;
          ph = PH_REF0;
        end
        PH_REF0: begin
          put(b, ST_BYTE);
          top = b[7:5];
          if (top == REF_TOP_LONG) begin
            ref_cnt = {27'd0, b[4:0]};
            ph = PH_REFL;
            fcnt = 0;
          end else if (top > REF_TOP_MAX) begin
            abort(ST_BAD_REF);
          end else begin
            ref_cnt = {29'd0, top};
            to_refs();
          end
        end
        PH_REFL: begin
          put(b, ST_BYTE);
          ref_cnt = {ref_cnt[23:0], b};
          fcnt++;
          if (fcnt == 3) begin
            if (ref_cnt > REF_MAX) begin
              abort(ST_BAD_REF);
            end else begin
              pay_len = (ref_cnt + 8) / 8;
              ph = PH_RET;
              fcnt = 0;
            end
          end
        end
        PH_RET: begin
          put(b, ST_BYTE);
          fcnt++;
          if (fcnt >= pay_len) to_refs();
        end
        PH_REFS: begin
          put(b, ST_BYTE);
          fcnt++;
          if (fcnt >= pay_len) to_page();
        end
        PH_PAGE: begin
          put(b, ST_BYTE);
          fcnt++;
          if (fcnt >= pay_len) begin
            ph = PH_LEN;
            fcnt = 0;
            pay_len = 0;
          end
        end
        PH_LEN: begin
          held[fcnt[1:0]] = b;
          pay_len = {pay_len[23:0], b};
          fcnt++;
          if (fcnt == 4) begin
            if (pay_len == LEN_INDEF) begin
              abort(ST_INDEF_LEN);
            end else if (ty == TYPE_COMMENT) begin
              if (pay_len < 4) begin
                abort(ST_BAD_EXT);
              end else begin
                ph = PH_EXT;
                pay_idx = 0;
              end
            end else if (ty == TYPE_PAGE_INFO && pay_len != PAGE_INFO_LEN) begin
              abort(ST_PAGE_SIZE);
            end else if (ty == TYPE_EOF && pay_len != 0) begin
              abort(ST_EOF_LEN);
            end else begin
              for (int i = 0; i < 4; i++) put(held[i], ST_BYTE);
              if (ty == TYPE_EOF) begin
                put(8'h00, ST_CLEAN);
                eof_seen = 1;
              end else if (pay_len == 0) begin
                seg_close();
              end else begin
                ph = PH_PAY;
                pay_idx = 0;
              end
            end
          end
        end
        PH_PAY: begin
          if (ty == TYPE_PAGE_INFO && pay_idx >= 8 && pay_idx < 16) put(8'h00, ST_BYTE);
          else put(b, ST_BYTE);
          pay_idx++;
          if (pay_idx >= pay_len) seg_close();
        end
        PH_EXT: begin
          held[4 + pay_idx[1:0]] = b;
          pay_idx++;
          if (pay_idx == 4) begin
            word = {held[4], held[5], held[6], held[7]};
            if (word == EXT_WORD_ONE || word == EXT_WORD_TWO) begin
              six = (word == EXT_WORD_TWO);
              put(8'h00, ST_BYTE);
              put(8'h00, ST_BYTE);
              put(8'h00, ST_BYTE);
              put(six ? 8'd6 : 8'd5, ST_BYTE);
              for (int i = 4; i < 8; i++) put(held[i], ST_BYTE);
              put(8'h00, ST_BYTE);
              if (six) put(8'h00, ST_BYTE);
              if (pay_len == 4) seg_close();
              else ph = PH_DROP;
            end else begin
              abort(ST_BAD_EXT);
            end
          end
        end
        PH_DROP: begin
          pay_idx++;
          if (pay_idx >= pay_len) seg_close();
        end
        default: seg_close();
      endcase
    end
    if (l) begin
      if (!eof_seen && !stream_bad) begin
        if (ph == PH_SEG && fcnt == 0) put(8'h00, ST_CLEAN);
        else put(8'h00, ST_TRUNC);
      end
      filter_reset();
    end
    if (step_out.size() > 0) step_out[step_out.size() - 1].lst = 1'b1;
  endtask

  task automatic plan_row(input logic [7:0] b, input logic l, input int n,
                          input res_t r0, input res_t r1);
    row_t r;
    r.b = b;
    r.l = l;
    r.n = n;
    r.r0 = r0;
    r.r1 = r1;
    plan.push_back(r);
  endtask

  // offers one item, waits for it to be taken and books its results
  task automatic push_item(input logic [7:0] b, input logic l, input int n,
                           input res_t r0, input res_t r1, output bit act);
    while ($urandom_range(99) < tx_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    stream_last <= l;
    do @(posedge clk); while (!in_ready);
    filter_byte(b, l, act);
    if (n < 0) begin
      foreach (step_out[k]) filtered_q.push_back(step_out[k]);
    end else begin
      if (n > 0) filtered_q.push_back(r0);
      if (n > 1) filtered_q.push_back(r1);
    end
  endtask

  task automatic drain();
    do begin
      in_valid <= 1'b0;
      @(posedge clk);
    end while (filtered_q.size() != 0);
  endtask

  function automatic void push_word(input logic [31:0] v);
    for (int i = 3; i >= 0; i--) strm.push_back(v[8*i +: 8]);
  endfunction

  task automatic add_segment(input seg_kind_t kind);
    logic [31:0] num;
    logic [31:0] cnt;
    logic [31:0] len;
    logic [31:0] word;
    logic [5:0]  ty;
    logic [7:0]  flags;
    int          wid;
    case ($urandom_range(7))
      0: num = 0;
      1: num = $urandom_range(1) ? 32'd256 : $urandom_range(1, 255);
      2: num = 257;
      3: num = 65536;
      4: num = 65537;
      5: num = 32'hffff_ffff;
      6: num = $urandom_range(257, 65536);
      default: num = $urandom;
    endcase
    case (kind)
      SEG_PAGE, SEG_PAGE_SIZE: ty = TYPE_PAGE_INFO;
      SEG_COMMENT, SEG_SHORT_NOTE, SEG_BAD_WORD: ty = TYPE_COMMENT;
      SEG_EOF, SEG_EOF_LEN: ty = TYPE_EOF;
      SEG_PLAIN: begin
        do ty = 6'($urandom);
        while (ty == TYPE_PAGE_INFO || ty == TYPE_EOF || ty == TYPE_COMMENT);
      end
      default: ty = 6'($urandom);
    endcase
    flags = {1'($urandom), 1'($urandom), ty};
    push_word(num);
    strm.push_back(flags);
    if (kind == SEG_BAD_SHORT) begin
      strm.push_back({$urandom_range(1) ? 3'd5 : 3'd6, 5'($urandom)});
      return;
    end
    if (kind == SEG_BAD_LONG || kind == SEG_NEAR_LIMIT || $urandom_range(5) == 0) begin
      if (kind == SEG_BAD_LONG) cnt = $urandom_range(REF_MAX + 1, 32'h1fff_ffff);
      else if (kind == SEG_NEAR_LIMIT) cnt = REF_MAX - $urandom_range(1);
      else cnt = $urandom_range(10);
      strm.push_back({REF_TOP_LONG, cnt[28:24]});
      strm.push_back(cnt[23:16]);
      strm.push_back(cnt[15:8]);
      strm.push_back(cnt[7:0]);
      if (kind == SEG_BAD_LONG) return;
      if (kind == SEG_NEAR_LIMIT) begin
        repeat ($urandom_range(1, 5)) strm.push_back(8'($urandom));
        return;
      end
      repeat ((cnt + 8) / 8) strm.push_back(8'($urandom));
    end else begin
      cnt = $urandom_range(4);
      strm.push_back({cnt[2:0], 5'($urandom)});
    end
    wid = (num > SEG_NUM_WIDE4) ? 4 : ((num > SEG_NUM_WIDE2) ? 2 : 1);
    repeat (cnt * wid) strm.push_back(8'($urandom));
    repeat (flags[6] ? 4 : 1) strm.push_back(8'($urandom));
    case (kind)
      SEG_PAGE: len = PAGE_INFO_LEN;
      SEG_PAGE_SIZE: begin
        case ($urandom_range(3))
          0: len = 18;
          1: len = 20;
          2: len = 0;
          default: len = $urandom_range(21, 32'hffff_fffe);
        endcase
      end
      SEG_COMMENT: len = 4 + $urandom_range(3);
      SEG_SHORT_NOTE: len = $urandom_range(3);
      SEG_BAD_WORD: len = 4 + $urandom_range(2);
      SEG_EOF: len = 0;
      SEG_EOF_LEN: len = $urandom_range(1) ? 32'd1 : $urandom_range(1, 32'hffff_fffe);
      SEG_INDEF: len = LEN_INDEF;
      default: len = ($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(6);
    endcase
    push_word(len);
    if (kind inside {SEG_INDEF, SEG_SHORT_NOTE, SEG_PAGE_SIZE, SEG_EOF_LEN}) return;
    if (kind == SEG_COMMENT || kind == SEG_BAD_WORD) begin
      if (kind == SEG_COMMENT) begin
        word = $urandom_range(1) ? EXT_WORD_TWO : EXT_WORD_ONE;
      end else begin
        do begin
          case ($urandom_range(2))
            0: word = EXT_WORD_ONE + 1;
            1: word = EXT_WORD_ONE ^ (32'd1 << $urandom_range(31));
            default: word = $urandom;
          endcase
        end while (word == EXT_WORD_ONE || word == EXT_WORD_TWO);
      end
      push_word(word);
      repeat (len - 4) strm.push_back(8'($urandom));
    end else begin
      repeat (len) strm.push_back(8'($urandom));
    end
  endtask

  task automatic make_stream();
    int pick;
    int cut;
    strm.delete();
    pick = $urandom_range(99);
    if (pick < 60) begin
      repeat ($urandom_range(1, 3)) add_segment(seg_kind_t'($urandom_range(SEG_PLAIN, SEG_COMMENT)));
      case ($urandom_range(2))
        0: begin
          add_segment(SEG_EOF);
          repeat ($urandom_range(2)) strm.push_back(8'($urandom));
        end
        1: ;
        default: begin
          cut = $urandom_range(1, strm.size() - 1);
          while (strm.size() > cut) void'(strm.pop_back());
        end
      endcase
    end else if (pick < 85) begin
      if ($urandom_range(1)) add_segment(SEG_PLAIN);
      add_segment(seg_kind_t'($urandom_range(SEG_BAD_SHORT, SEG_EOF_LEN)));
      repeat ($urandom_range(2)) strm.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 12)) strm.push_back(8'($urandom));
    end
  endtask

  function automatic void note_miss(input string why, input res_t want);
    misses++;
    if (misses <= 10)
      $display("%s: expected byte %02h status %0d last %0b, got byte %02h status %0d last %0b",
               why, want.b, want.st, want.lst, out_byte, status, run_last);
  endfunction

  // receiver: checks each result item and throttles out_ready
  always @(posedge clk) begin
    res_t want;
    if (!rst && out_valid && out_ready) begin
      if (filtered_q.size() == 0) begin
        note_miss("unexpected item", NIL);
      end else begin
        want = filtered_q.pop_front();
        if (out_byte !== want.b || status !== want.st || run_last !== want.lst)
          note_miss("mismatch", want);
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_done != hold_ask) begin
      hold_done = hold_ask;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !($urandom_range(99) < rx_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    bit act;
    int rnd_items;
    int mode;
    int cur_mode;
    int waited;
    rnd_items = 0;
    cur_mode = 0;
    waited = 0;
    filter_reset();

    // bad short referred-to count right after reset
    plan_row(8'hFF, 1'b0, 1, res_t'{8'hFF, ST_BYTE, 1'b1}, NIL);
    plan_row(8'hFF, 1'b0, BY_MODEL, NIL, NIL);
    plan_row(8'hFF, 1'b0, BY_MODEL, NIL, NIL);
    plan_row(8'hFF, 1'b0, BY_MODEL, NIL, NIL);
    plan_row(8'hFF, 1'b0, BY_MODEL, NIL, NIL);
    plan_row(8'hA0, 1'b0, 2, res_t'{8'hA0, ST_BYTE, 1'b0}, res_t'{8'h00, ST_BAD_REF, 1'b1});
    plan_row(8'h00, 1'b1, 0, NIL, NIL);
    // empty end-of-file segment, then a trailing byte that is dropped
    plan_row(8'h00, 1'b0, 1, res_t'{8'h00, ST_BYTE, 1'b1}, NIL);
    plan_row(8'h00, 1'b0, BY_MODEL, NIL, NIL);
    plan_row(8'h00, 1'b0, BY_MODEL, NIL, NIL);
    plan_row(8'h00, 1'b0, BY_MODEL, NIL, NIL);
    plan_row({2'b00, TYPE_EOF}, 1'b0, BY_MODEL, NIL, NIL);
    plan_row(8'h00, 1'b0, BY_MODEL, NIL, NIL);
    plan_row(8'h00, 1'b0, BY_MODEL, NIL, NIL);
    plan_row(8'h00, 1'b0, 0, NIL, NIL);
    plan_row(8'h00, 1'b0, 0, NIL, NIL);
    plan_row(8'h00, 1'b0, 0, NIL, NIL);
    plan_row(8'h00, 1'b0, BY_MODEL, NIL, NIL);
    plan_row(8'h5A, 1'b1, 0, NIL, NIL);
    // one-byte stream
    plan_row(8'hA5, 1'b1, 2, res_t'{8'hA5, ST_BYTE, 1'b0}, res_t'{8'h00, ST_TRUNC, 1'b1});

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) push_item(plan[i].b, plan[i].l, plan[i].n, plan[i].r0, plan[i].r1, act);

    while (rnd_items < RAND_ITEMS) begin
      mode = rnd_items * 4 / RAND_ITEMS;
      if (mode != cur_mode) begin
        drain();
        cur_mode = mode;
        case (mode)
          1: begin tx_pct = 47; rx_pct = 0; end
          2: begin tx_pct = 0; rx_pct = 47; end
          default: begin tx_pct = 34; rx_pct = 34; end
        endcase
      end
      make_stream();
      foreach (strm[i]) begin
        push_item(strm[i], i == strm.size() - 1, BY_MODEL, NIL, NIL, act);
        if (act) rnd_items++;
        // long receiver hold while bytes keep coming
        if (rnd_items >= 10 && hold_ask == 0) hold_ask++;
      end
    end

    do begin
      in_valid <= 1'b0;
      @(posedge clk);
      waited++;
    end while (filtered_q.size() != 0 && waited < 20000);
    repeat (20) @(posedge clk);
    if (filtered_q.size() != 0) note_miss("missing item", filtered_q[0]);
    if (misses == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/jbig2_smf_pkg.sv
hw/rtl/jbig2_smf_front.sv
hw/rtl/jbig2_smf_queue.sv
hw/rtl/jbig2_smf_back.sv
hw/rtl/jbig2_segment_metadata_filter.sv
hw/rtl/jbig2_smf_checker.sv
verif/jbig2_segment_metadata_filter_test.sv
